>>> rtl/swbi_pkg.sv
// Shared constants and types for the stack with bottom increment.
`timescale 1ns / 1ps

package swbi_pkg;

  // Fixed field widths of the command and result transfers.
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 11;
  localparam int LEVEL_W = 11;
  localparam int MODE_W  = 2;

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INC  = 2'd2;

  // Word returned by a pop that finds the stack empty.
  localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

  // One result as it waits for the output register.
  typedef struct packed {
    logic [DATA_W-1:0]  popped;
    logic               was_empty;
    logic               was_full;
    logic [LEVEL_W-1:0] fill_level;
  } res_t;

endpackage

>>> rtl/swbi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module swbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/stack_with_bottom_increment.sv
// Top level of the bounded stack with a bulk increment of its bottom entries.
`timescale 1ns / 1ps

// A bounded stack of DEPTH signed 32-bit words held in one RAM with a
// registered read port. Commands are taken one at a time; in_stall is high
// while a command is being worked on. A push, an unused mode, a pop of an
// empty stack and an increment that touches nothing go straight to the finish
// state; a pop with data first waits in a read state for the RAM read data;
// an increment runs a read state and a write state for each of its min(count,
// fill) bottom entries, a read-modify-write on the single RAM read port and
// the one shared adder. A finished result sits in an output register, so the
// next command can be taken while it waits. No clearing pass is needed after
// reset: only entries below the fill level are ever read.
module stack_with_bottom_increment import swbi_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [MODE_W-1:0]         mode,
  input  logic signed [DATA_W-1:0]  value,
  input  logic [COUNT_W-1:0]        count,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  popped,
  output logic                      was_empty,
  output logic                      was_full,
  output logic [LEVEL_W-1:0]        fill_level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [FW-1:0] FULL_LEVEL = FW'(DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_POP_RD = 5'b00010,
    ST_INC_RD = 5'b00100,
    ST_INC_WR = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [FW-1:0]     fill, fill_next;
  logic [FW-1:0]     idx, idx_next;
  logic [FW-1:0]     limit, limit_next;
  logic [DATA_W-1:0] amount, amount_next;
  res_t              res, res_next;

  logic              in_xfer;
  logic              out_free;
  logic [COUNT_W-1:0] fill_wide;
  logic [FW-1:0]     inc_span;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] sum;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Number of bottom entries an increment touches: min(count, fill).
  assign fill_wide = COUNT_W'(fill);
  assign inc_span  = (count < fill_wide) ? FW'(count) : fill;

  // The shared adder used by every read-modify-write step.
  assign sum = rd_data + amount;

  // RAM port selection: pushes write in idle, increments write back the sum.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[AW-1:0];
    wr_data = value;
    if (state == ST_IDLE) begin
      wr_en = in_xfer && (mode == MODE_PUSH) && (fill != FULL_LEVEL);
    end else if (state == ST_INC_WR) begin
      wr_en   = 1'b1;
      wr_addr = idx[AW-1:0];
      wr_data = sum;
    end
  end

  // Pops read the top entry at the transfer; increment steps read the index.
  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr = AW'(fill - FW'(1));
    end else begin
      rd_addr = idx[AW-1:0];
    end
  end

  swbi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: decode a command, run its steps, then hand the result over.
  always_comb begin
    state_next  = state;
    fill_next   = fill;
    idx_next    = idx;
    limit_next  = limit;
    amount_next = amount;
    res_next    = res;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          res_next.popped    = '0;
          res_next.was_empty = 1'b0;
          res_next.was_full  = 1'b0;
          state_next         = ST_FINISH;
          if (mode == MODE_PUSH) begin
            if (fill == FULL_LEVEL) begin
              res_next.was_full = 1'b1;
            end else begin
              fill_next = fill + FW'(1);
            end
          end else if (mode == MODE_POP) begin
            if (fill == '0) begin
              res_next.popped    = EMPTY_WORD;
              res_next.was_empty = 1'b1;
            end else begin
              fill_next  = fill - FW'(1);
              state_next = ST_POP_RD;
            end
          end else if (mode == MODE_INC) begin
            idx_next    = '0;
            limit_next  = inc_span;
            amount_next = value;
            if (inc_span != '0) begin
              state_next = ST_INC_RD;
            end
          end
          res_next.fill_level = LEVEL_W'(fill_next);
        end
      end
      ST_POP_RD: begin
        res_next.popped = rd_data;
        state_next      = ST_FINISH;
      end
      ST_INC_RD: begin
        state_next = ST_INC_WR;
      end
      ST_INC_WR: begin
        idx_next = idx + FW'(1);
        if (idx + FW'(1) == limit) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_INC_RD;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    limit  <= limit_next;
    amount <= amount_next;
    res    <= res_next;
  end

  // Output register: loaded from the finished result when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      popped     <= res.popped;
      was_empty  <= res.was_empty;
      was_full   <= res.was_full;
      fill_level <= res.fill_level;
    end
  end

  // The fill level never passes the capacity.
  assert property (@(posedge clk) disable iff (rst) fill <= FULL_LEVEL)
    else $error("fill level above capacity");

  // The fill level changes only when a command is taken in idle.
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> (fill == $past(fill)))
    else $error("fill level changed during a command");

  // A write-back step always stays inside the increment span.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_INC_WR) |-> (idx < limit && limit <= fill))
    else $error("increment step outside its span");

  // A pop of a non-empty stack goes to the read step.
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && mode == MODE_POP && fill != '0) |=> (state == ST_POP_RD))
    else $error("pop did not read the top entry");

  // A result never carries both flags.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(was_empty && was_full))
    else $error("both flags set in one result");

endmodule
